>>> sv/duri_pkg.sv
package duri_pkg;

    typedef enum logic [3:0] {
        PH_PREFIX  = 4'b0001,
        PH_META    = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_HALT    = 4'b1000
    } phase_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_PREFIX = 3'd1;
    localparam logic [2:0] ST_NO_COMMA  = 3'd2;
    localparam logic [2:0] ST_BAD_B64   = 3'd3;
    localparam logic [2:0] ST_BAD_PCT   = 3'd4;

    localparam int unsigned PREFIX_LEN = 5;

    // ";base64" as it sits in the seven-character metadata window.
    localparam logic [55:0] MARKER = 56'h3B626173653634;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PCT   = 8'h25;

    // Character class that the front end attaches to each transfer.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       is_ws;
        logic       is_eq;
        logic       is_pct;
        logic       is_comma;
        logic       sx_ok;
        logic [5:0] sx;
        logic       hex_ok;
        logic [3:0] hex;
    } class_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h64;   // d
            3'd1:    c = 8'h61;   // a
            3'd2:    c = 8'h74;   // t
            3'd3:    c = 8'h61;   // a
            3'd4:    c = 8'h3A;   // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> sv/duri_text_if.sv
interface duri_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

>>> sv/duri_result_if.sv
interface duri_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic [2:0] status;

    modport source (output valid, output out_byte, output out_valid, output out_last,
                    output status, input ready);
    modport sink   (input valid, input out_byte, input out_valid, input out_last,
                    input status, output ready);
endinterface

>>> sv/duri_front.sv
module duri_front (
    duri_text_if.sink          text,
    input  duri_pkg::qstat_t   qstat,
    output logic               push,
    output duri_pkg::class_t   cls
);

    logic [7:0] c;

    assign c          = text.in_char;
    assign text.ready = !qstat.full;
    assign push       = text.valid && !qstat.full;

    always_comb
    begin
        cls          = '0;
        cls.ch       = c;
        cls.last     = text.in_last;
        cls.is_ws    = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
        cls.is_eq    = (c == duri_pkg::CH_EQ);
        cls.is_pct   = (c == duri_pkg::CH_PCT);
        cls.is_comma = (c == duri_pkg::CH_COMMA);

        if (c >= 8'h41 && c <= 8'h5A)
        begin
            cls.sx_ok = 1'b1;
            cls.sx    = 6'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            cls.sx_ok = 1'b1;
            cls.sx    = 6'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            cls.sx_ok = 1'b1;
            cls.sx    = 6'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2B)
        begin
            cls.sx_ok = 1'b1;
            cls.sx    = 6'd62;
        end
        else if (c == 8'h2F)
        begin
            cls.sx_ok = 1'b1;
            cls.sx    = 6'd63;
        end

        if (c >= 8'h30 && c <= 8'h39)
        begin
            cls.hex_ok = 1'b1;
            cls.hex    = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            cls.hex_ok = 1'b1;
            cls.hex    = 4'(c - 8'h61 + 8'd10);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            cls.hex_ok = 1'b1;
            cls.hex    = 4'(c - 8'h41 + 8'd10);
        end
    end

endmodule

>>> sv/duri_queue.sv
module duri_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  duri_pkg::class_t   wdata,
    input  logic               pop,
    output duri_pkg::class_t   rdata,
    output duri_pkg::qstat_t   qstat
);

    duri_pkg::class_t mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign qstat.full  = (count_reg == 2'd2);
    assign qstat.empty = (count_reg == 2'd0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign rdata       = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg ^ do_push;
        rptr_next  = rptr_reg ^ do_pop;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

>>> sv/duri_back.sv
module duri_back (
    input  logic               clk,
    input  logic               rst_n,
    input  duri_pkg::class_t   head,
    input  duri_pkg::qstat_t   qstat,
    output logic               pop,
    duri_result_if.source      result
);

    duri_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  pidx_reg, pidx_next;
    logic [55:0] win_reg, win_next;
    logic        b64_reg, b64_next;
    logic [11:0] acc_reg, acc_next;
    logic [3:0]  pend_reg, pend_next;
    logic [1:0]  esc_reg, esc_next;
    logic [3:0]  hnib_reg, hnib_next;
    logic [2:0]  err_reg, err_next;

    logic        ovalid_reg, ovalid_next;
    logic [7:0]  obyte_reg, obyte_next;
    logic        obv_reg, obv_next;
    logic        olast_reg, olast_next;
    logic [2:0]  ost_reg, ost_next;

    logic        have;
    logic [7:0]  byte_val;
    logic [2:0]  st;
    logic [55:0] win_shift;
    logic [11:0] acc_new;
    logic [3:0]  pend_sum;
    logic [3:0]  pend_left;

    assign pop       = !qstat.empty && (!ovalid_reg || result.ready);
    assign win_shift = {win_reg[47:0], head.ch};
    assign acc_new   = {acc_reg[5:0], head.sx};
    assign pend_sum  = pend_reg + 4'd6;
    assign pend_left = pend_sum - 4'd8;

    always_comb
    begin
        phase_next = phase_reg;
        pidx_next  = pidx_reg;
        win_next   = win_reg;
        b64_next   = b64_reg;
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        esc_next   = esc_reg;
        hnib_next  = hnib_reg;
        err_next   = err_reg;
        have       = 1'b0;
        byte_val   = 8'h00;
        st         = duri_pkg::ST_OK;

        if (pop)
        begin
            case (phase_reg)
                duri_pkg::PH_PREFIX:
                begin
                    if (32'(pidx_reg) < duri_pkg::PREFIX_LEN
                        && head.ch == duri_pkg::prefix_char(pidx_reg))
                    begin
                        pidx_next = pidx_reg + 3'd1;
                        if (32'(pidx_reg) == duri_pkg::PREFIX_LEN - 1)
                        begin
                            phase_next = duri_pkg::PH_META;
                            win_next   = '0;
                        end
                    end
                    else
                    begin
                        err_next   = duri_pkg::ST_NO_PREFIX;
                        phase_next = duri_pkg::PH_HALT;
                    end
                end
                duri_pkg::PH_META:
                begin
                    if (head.is_comma)
                    begin
                        phase_next = duri_pkg::PH_PAYLOAD;
                    end
                    else
                    begin
                        win_next = win_shift;
                        if (win_shift == duri_pkg::MARKER)
                        begin
                            b64_next = 1'b1;
                        end
                    end
                end
                duri_pkg::PH_PAYLOAD:
                begin
                    if (b64_reg)
                    begin
                        if (head.is_ws)
                        begin
                            acc_next = acc_reg;
                        end
                        else if (head.is_eq)
                        begin
                            phase_next = duri_pkg::PH_HALT;
                        end
                        else if (!head.sx_ok)
                        begin
                            err_next   = duri_pkg::ST_BAD_B64;
                            phase_next = duri_pkg::PH_HALT;
                        end
                        else if (pend_sum >= 4'd8)
                        begin
                            // A full byte is ready; keep only the bits left below it.
                            have      = 1'b1;
                            pend_next = pend_left;
                            case (pend_left[2:1])
                                2'd0:
                                begin
                                    byte_val = acc_new[7:0];
                                    acc_next = 12'd0;
                                end
                                2'd1:
                                begin
                                    byte_val = acc_new[9:2];
                                    acc_next = {10'd0, acc_new[1:0]};
                                end
                                default:
                                begin
                                    byte_val = acc_new[11:4];
                                    acc_next = {8'd0, acc_new[3:0]};
                                end
                            endcase
                        end
                        else
                        begin
                            acc_next  = acc_new;
                            pend_next = pend_sum;
                        end
                    end
                    else
                    begin
                        if (esc_reg == 2'd0)
                        begin
                            if (head.is_pct)
                            begin
                                esc_next = 2'd1;
                            end
                            else
                            begin
                                have     = 1'b1;
                                byte_val = head.ch;
                            end
                        end
                        else if (!head.hex_ok)
                        begin
                            err_next   = duri_pkg::ST_BAD_PCT;
                            phase_next = duri_pkg::PH_HALT;
                        end
                        else if (esc_reg == 2'd1)
                        begin
                            hnib_next = head.hex;
                            esc_next  = 2'd2;
                        end
                        else
                        begin
                            have     = 1'b1;
                            byte_val = {hnib_reg, head.hex};
                            esc_next = 2'd0;
                        end
                    end
                end
                duri_pkg::PH_HALT:
                begin
                    phase_next = phase_reg;
                end
                default:
                begin
                    phase_next = duri_pkg::PH_HALT;
                end
            endcase

            if (head.last)
            begin
                if (phase_next == duri_pkg::PH_PREFIX)
                begin
                    st = duri_pkg::ST_NO_PREFIX;
                end
                else if (phase_next == duri_pkg::PH_META)
                begin
                    st = duri_pkg::ST_NO_COMMA;
                end
                else if (phase_next == duri_pkg::PH_PAYLOAD && !b64_next && esc_next != 2'd0)
                begin
                    st = duri_pkg::ST_BAD_PCT;
                end
                else
                begin
                    st = err_next;
                end

                if (st != duri_pkg::ST_OK)
                begin
                    have     = 1'b0;
                    byte_val = 8'h00;
                end

                // The next URI starts from a clean state.
                phase_next = duri_pkg::PH_PREFIX;
                pidx_next  = 3'd0;
                win_next   = '0;
                b64_next   = 1'b0;
                acc_next   = 12'd0;
                pend_next  = 4'd0;
                esc_next   = 2'd0;
                hnib_next  = 4'd0;
                err_next   = duri_pkg::ST_OK;
            end
        end
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        obyte_next  = obyte_reg;
        obv_next    = obv_reg;
        olast_next  = olast_reg;
        ost_next    = ost_reg;
        if (pop && (have || head.last))
        begin
            ovalid_next = 1'b1;
            obyte_next  = byte_val;
            obv_next    = have;
            olast_next  = head.last;
            ost_next    = st;
        end
        else if (result.ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= duri_pkg::PH_PREFIX;
            pidx_reg   <= 3'd0;
            win_reg    <= '0;
            b64_reg    <= 1'b0;
            acc_reg    <= 12'd0;
            pend_reg   <= 4'd0;
            esc_reg    <= 2'd0;
            hnib_reg   <= 4'd0;
            err_reg    <= duri_pkg::ST_OK;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pidx_reg   <= pidx_next;
            win_reg    <= win_next;
            b64_reg    <= b64_next;
            acc_reg    <= acc_next;
            pend_reg   <= pend_next;
            esc_reg    <= esc_next;
            hnib_reg   <= hnib_next;
            err_reg    <= err_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obyte_reg <= obyte_next;
        obv_reg   <= obv_next;
        olast_reg <= olast_next;
        ost_reg   <= ost_next;
    end

    assign result.valid     = ovalid_reg;
    assign result.out_byte  = obyte_reg;
    assign result.out_valid = obv_reg;
    assign result.out_last  = olast_reg;
    assign result.status    = ost_reg;

endmodule

>>> sv/data_uri_payload_decoder.sv
// Channel   Role    Payload                                   Transfer when
// text      sink    in_char[7:0], in_last                     valid && ready
// result    source  out_byte[7:0], out_valid, out_last,       valid && ready
//                   status[2:0]
//
// One character per cycle is taken while the queue has room; a character
// is written into the queue and then into the result register.
// The back end decodes one queued character per cycle, limited only by the
// single result register, so a stalled consumer fills the two-entry queue
// and then drops text.ready. Reset is asynchronous and active low and
// returns the decoder to prefix matching with both sides empty.
module data_uri_payload_decoder (
    input  logic          clk,
    input  logic          rst_n,
    duri_text_if.sink     text,
    duri_result_if.source result
);

    duri_pkg::class_t cls;
    duri_pkg::class_t head;
    duri_pkg::qstat_t qstat;
    logic             push;
    logic             pop;

    duri_front u_front (
        .text  (text),
        .qstat (qstat),
        .push  (push),
        .cls   (cls)
    );

    duri_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cls),
        .pop   (pop),
        .rdata (head),
        .qstat (qstat)
    );

    duri_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .qstat  (qstat),
        .pop    (pop),
        .result (result)
    );

`ifndef ASSERT_OFF
    a_err_drops_byte: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status != duri_pkg::ST_OK |-> !result.out_valid)
        else $error("error status carries a byte");

    a_status_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.out_last |-> result.status == duri_pkg::ST_OK)
        else $error("status set on a non-final result");

    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.full && qstat.empty) && !(pop && qstat.empty))
        else $error("queue state inconsistent");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.full |-> !text.ready)
        else $error("input taken with the queue full");
`endif

endmodule

>>> bench/tb_data_uri_payload_decoder.sv
module tb_data_uri_payload_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIRECTED_N   = 31;
    localparam int RANDOM_ITEMS = 720;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 20;

    localparam logic [1:0] ESC_IDLE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [7:0] PREFIX_TEXT [5] = '{8'h64, 8'h61, 8'h74, 8'h61, 8'h3A};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
        logic [2:0] status;
    } decode_result_t;

    typedef struct packed {
        logic [7:0]     ch;
        logic           last;
        logic           typed;
        decode_result_t want;
    } stim_row_t;

    localparam decode_result_t NO_RESULT = '0;

    logic clk;
    logic rst_n;

    duri_text_if   text_ch ();
    duri_result_if result_ch ();

    data_uri_payload_decoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (result_ch)
    );

    // Directed URIs: a mismatch on the first character, a missing comma, a bad
    // percent digit, and a base64 payload whose final character also ends a byte.
    stim_row_t directed_rows [DIRECTED_N] = '{
        '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, duri_pkg::ST_NO_PREFIX}},
        '{"d", 1'b0, 1'b0, NO_RESULT}, '{"a", 1'b0, 1'b0, NO_RESULT},
        '{"t", 1'b0, 1'b0, NO_RESULT}, '{"a", 1'b0, 1'b0, NO_RESULT},
        '{":", 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, duri_pkg::ST_NO_COMMA}},
        '{"d", 1'b0, 1'b0, NO_RESULT}, '{"a", 1'b0, 1'b0, NO_RESULT},
        '{"t", 1'b0, 1'b0, NO_RESULT}, '{"a", 1'b0, 1'b0, NO_RESULT},
        '{":", 1'b0, 1'b0, NO_RESULT}, '{",", 1'b0, 1'b0, NO_RESULT},
        '{"%", 1'b0, 1'b0, NO_RESULT},
        '{"G", 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, duri_pkg::ST_BAD_PCT}},
        '{"d", 1'b0, 1'b0, NO_RESULT}, '{"a", 1'b0, 1'b0, NO_RESULT},
        '{"t", 1'b0, 1'b0, NO_RESULT}, '{"a", 1'b0, 1'b0, NO_RESULT},
        '{":", 1'b0, 1'b0, NO_RESULT}, '{";", 1'b0, 1'b0, NO_RESULT},
        '{"b", 1'b0, 1'b0, NO_RESULT}, '{"a", 1'b0, 1'b0, NO_RESULT},
        '{"s", 1'b0, 1'b0, NO_RESULT}, '{"e", 1'b0, 1'b0, NO_RESULT},
        '{"6", 1'b0, 1'b0, NO_RESULT}, '{"4", 1'b0, 1'b0, NO_RESULT},
        '{",", 1'b0, 1'b0, NO_RESULT}, '{" ", 1'b0, 1'b0, NO_RESULT},
        '{"/", 1'b0, 1'b0, NO_RESULT},
        '{"w", 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, duri_pkg::ST_OK}}
    };

    string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    string hex_digits   = "0123456789abcdefABCDEF";
    string ws_chars     = "\040\011\012\013\014\015";

    // Decoder state as the predictor sees it.
    duri_pkg::phase_t dec_phase;
    logic [2:0]  dec_prefix_idx;
    logic [55:0] dec_window;
    logic        dec_b64;
    logic [11:0] dec_acc;
    logic [3:0]  dec_pending;
    logic [1:0]  dec_esc;
    logic [3:0]  dec_hi;
    logic [2:0]  dec_err;

    decode_result_t pending_results [$];
    logic [7:0]     uri_text [$];

    int chars_sent;
    int fail_count;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;

    function automatic int sextet_value(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return int'(c) - 65;
        if (c >= "a" && c <= "z") return int'(c) - 97 + 26;
        if (c >= "0" && c <= "9") return int'(c) - 48 + 52;
        if (c == "+") return 62;
        if (c == "/") return 63;
        return -1;
    endfunction

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - 48;
        if (c >= "a" && c <= "f") return int'(c) - 97 + 10;
        if (c >= "A" && c <= "F") return int'(c) - 65 + 10;
        return -1;
    endfunction

    function automatic void clear_decoder();
        dec_phase      = duri_pkg::PH_PREFIX;
        dec_prefix_idx = '0;
        dec_window     = '0;
        dec_b64        = 1'b0;
        dec_acc        = '0;
        dec_pending    = '0;
        dec_esc        = ESC_IDLE;
        dec_hi         = '0;
        dec_err        = duri_pkg::ST_OK;
    endfunction

    // Advances the predicted state by one character; returns 1 when a result is due.
    function automatic bit decode_char(input logic [7:0] c, input logic l,
                                       output decode_result_t r);
        bit         have;
        logic [7:0] val;
        int         sx;
        int         hx;
        logic [2:0] st;
        have = 1'b0;
        val  = '0;
        r    = '0;
        sx   = sextet_value(c);
        hx   = nibble_of(c);
        case (dec_phase)
            duri_pkg::PH_PREFIX:
            begin
                if (dec_prefix_idx < duri_pkg::PREFIX_LEN
                    && c == PREFIX_TEXT[dec_prefix_idx])
                begin
                    dec_prefix_idx = dec_prefix_idx + 3'd1;
                    if (dec_prefix_idx == duri_pkg::PREFIX_LEN)
                    begin
                        dec_phase  = duri_pkg::PH_META;
                        dec_window = '0;
                    end
                end
                else
                begin
                    dec_err   = duri_pkg::ST_NO_PREFIX;
                    dec_phase = duri_pkg::PH_HALT;
                end
            end
            duri_pkg::PH_META:
            begin
                if (c == duri_pkg::CH_COMMA)
                    dec_phase = duri_pkg::PH_PAYLOAD;
                else
                begin
                    dec_window = {dec_window[47:0], c};
                    if (dec_window == duri_pkg::MARKER)
                        dec_b64 = 1'b1;
                end
            end
            duri_pkg::PH_PAYLOAD:
            begin
                if (dec_b64)
                begin
                    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                    begin
                        // Whitespace inside base64 text is skipped.
                    end
                    else if (c == duri_pkg::CH_EQ)
                        dec_phase = duri_pkg::PH_HALT;
                    else if (sx < 0)
                    begin
                        dec_err   = duri_pkg::ST_BAD_B64;
                        dec_phase = duri_pkg::PH_HALT;
                    end
                    else
                    begin
                        dec_acc     = {dec_acc[5:0], 6'(sx)};
                        dec_pending = dec_pending + 4'd6;
                        if (dec_pending >= 4'd8)
                        begin
                            dec_pending = dec_pending - 4'd8;
                            val         = 8'(dec_acc >> dec_pending);
                            have        = 1'b1;
                            dec_acc     = dec_acc & ((12'd1 << dec_pending) - 12'd1);
                        end
                    end
                end
                else if (dec_esc == ESC_IDLE)
                begin
                    if (c == duri_pkg::CH_PCT)
                        dec_esc = ESC_HIGH;
                    else
                    begin
                        val  = c;
                        have = 1'b1;
                    end
                end
                else if (hx < 0)
                begin
                    dec_err   = duri_pkg::ST_BAD_PCT;
                    dec_phase = duri_pkg::PH_HALT;
                end
                else if (dec_esc == ESC_HIGH)
                begin
                    dec_hi  = 4'(hx);
                    dec_esc = ESC_LOW;
                end
                else
                begin
                    val     = {dec_hi, 4'(hx)};
                    have    = 1'b1;
                    dec_esc = ESC_IDLE;
                end
            end
            default:
            begin
            end
        endcase

        if (!l)
        begin
            if (have)
                r = '{val, 1'b1, 1'b0, duri_pkg::ST_OK};
            return have;
        end

        if (dec_phase == duri_pkg::PH_PREFIX)
            st = duri_pkg::ST_NO_PREFIX;
        else if (dec_phase == duri_pkg::PH_META)
            st = duri_pkg::ST_NO_COMMA;
        else if (dec_phase == duri_pkg::PH_PAYLOAD && !dec_b64 && dec_esc != ESC_IDLE)
            st = duri_pkg::ST_BAD_PCT;
        else
            st = dec_err;
        if (st != duri_pkg::ST_OK)
            have = 1'b0;
        r = '{have ? val : 8'h00, have, 1'b1, st};
        clear_decoder();
        return 1'b1;
    endfunction

    function automatic logic [7:0] any_but(input logic [7:0] c);
        logic [7:0] x;
        do
        begin
            x = 8'($urandom_range(0, 255));
        end
        while (x == c);
        return x;
    endfunction

    function automatic logic [7:0] non_hex();
        logic [7:0] x;
        do
        begin
            x = 8'($urandom_range(0, 255));
        end
        while (nibble_of(x) >= 0);
        return x;
    endfunction

    function automatic logic [7:0] non_b64();
        logic [7:0] x;
        do
        begin
            x = 8'($urandom_range(0, 255));
        end
        while (sextet_value(x) >= 0 || x == CH_SPACE || (x >= CH_TAB && x <= CH_CR)
               || x == duri_pkg::CH_EQ);
        return x;
    endfunction

    function automatic void put_char(input logic [7:0] c);
        uri_text.insert(uri_text.size(), c);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i]);
    endfunction

    // Builds one URI: mostly well-formed with random content, the rest noise,
    // broken prefixes and metadata that never reaches a comma.
    function automatic void compose_uri();
        int kind;
        int n;
        int pick;
        int i;
        bit want_b64;
        uri_text.delete();
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            n = $urandom_range(1, 6);
            repeat (n) put_char(8'($urandom_range(0, 255)));
        end
        else if (kind < 20)
        begin
            n = $urandom_range(0, 4);
            for (i = 0; i < n; i++)
                put_char(PREFIX_TEXT[i]);
            if (n == 0 || $urandom_range(0, 1))
                put_char(8'($urandom_range(0, 255)));
        end
        else
        begin
            push_text("data:");
            if (kind < 28)
            begin
                n = $urandom_range(0, 8);
                repeat (n) put_char(any_but(duri_pkg::CH_COMMA));
            end
            else
            begin
                want_b64 = 1'b0;
                case ($urandom_range(0, 6))
                    0: ;
                    1:
                    begin
                        push_text(";base64");
                        want_b64 = 1'b1;
                    end
                    2:
                    begin
                        push_text("text/plain;base64");
                        want_b64 = 1'b1;
                    end
                    3: push_text("text/plain");
                    4:
                    begin
                        push_text(";base64;x=1");
                        want_b64 = 1'b1;
                    end
                    5: push_text(";base6");
                    default:
                    begin
                        n = $urandom_range(1, 6);
                        repeat (n) put_char(any_but(duri_pkg::CH_COMMA));
                    end
                endcase
                put_char(duri_pkg::CH_COMMA);
                n = $urandom_range(0, 12);
                for (i = 0; i < n; i++)
                begin
                    pick = $urandom_range(0, 99);
                    if (want_b64)
                    begin
                        if (pick < 82)
                            put_char(b64_alphabet[$urandom_range(0, 63)]);
                        else if (pick < 92)
                            put_char(ws_chars[$urandom_range(0, 5)]);
                        else if (pick < 95)
                            put_char(non_b64());
                        else
                        begin
                            put_char(duri_pkg::CH_EQ);
                            if ($urandom_range(0, 1))
                                put_char(8'($urandom_range(0, 255)));
                            break;
                        end
                    end
                    else
                    begin
                        if (pick < 60)
                            put_char(any_but(duri_pkg::CH_PCT));
                        else if (pick < 90)
                        begin
                            put_char(duri_pkg::CH_PCT);
                            put_char(hex_digits[$urandom_range(0, 21)]);
                            put_char(hex_digits[$urandom_range(0, 21)]);
                        end
                        else if (pick < 95)
                        begin
                            put_char(duri_pkg::CH_PCT);
                            if ($urandom_range(0, 1))
                                put_char(hex_digits[$urandom_range(0, 21)]);
                            put_char(non_hex());
                        end
                        else
                        begin
                            // Escape cut short by the end of the URI.
                            put_char(duri_pkg::CH_PCT);
                            if ($urandom_range(0, 1))
                                put_char(hex_digits[$urandom_range(0, 21)]);
                            break;
                        end
                    end
                end
            end
        end
    endfunction

    // Presents one character and waits for its transfer, then records what the
    // decoder must return for it.
    task automatic send_char(input logic [7:0] c, input logic l, input logic typed,
                             input decode_result_t want);
        decode_result_t got;
        bit             has;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            text_ch.valid <= 1'b0;
            @(posedge clk);
        end
        text_ch.valid   <= 1'b1;
        text_ch.in_char <= c;
        text_ch.in_last <= l;
        do
        begin
            @(posedge clk);
        end
        while (!text_ch.ready);
        has = decode_char(c, l, got);
        if (typed)
            pending_results.insert(pending_results.size(), want);
        else if (has)
            pending_results.insert(pending_results.size(), got);
        chars_sent++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : result_side
        decode_result_t want;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none,", $time);
                    $display("%0t:   got byte=%02h valid=%0b last=%0b status=%0d",
                             $time, result_ch.out_byte, result_ch.out_valid,
                             result_ch.out_last, result_ch.status);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result_ch.out_byte !== want.data_byte
                        || result_ch.out_valid !== want.byte_valid
                        || result_ch.out_last !== want.last
                        || result_ch.status !== want.status)
                    begin
                        $display("%0t: mismatch, expected byte=%02h valid=%0b last=%0b status=%0d",
                                 $time, want.data_byte, want.byte_valid, want.last,
                                 want.status);
                        $display("%0t:   got byte=%02h valid=%0b last=%0b status=%0d",
                                 $time, result_ch.out_byte, result_ch.out_valid,
                                 result_ch.out_last, result_ch.status);
                        fail_count++;
                    end
                end
            end
            result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin : text_side
        int r;
        int i;
        int phase_now;
        int phase_seen;
        fail_count      = 0;
        chars_sent      = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        phase_seen      = -1;
        clear_decoder();
        rst_n           = 1'b0;
        text_ch.valid   = 1'b0;
        text_ch.in_char = '0;
        text_ch.in_last = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < DIRECTED_N; r++)
            send_char(directed_rows[r].ch, directed_rows[r].last, directed_rows[r].typed,
                      directed_rows[r].want);

        while (chars_sent < DIRECTED_N + RANDOM_ITEMS)
        begin
            phase_now = ((chars_sent - DIRECTED_N) * 4) / RANDOM_ITEMS;
            if (phase_now > 3)
                phase_now = 3;
            if (phase_now != phase_seen)
            begin
                phase_seen = phase_now;
                // Hold the text side until every outstanding result has come back.
                text_ch.valid <= 1'b0;
                do
                begin
                    @(posedge clk);
                end
                while (pending_results.size() != 0);
                case (phase_now)
                    0:
                    begin
                        send_idle_pct  = 0;
                        recv_stall_pct = 0;
                    end
                    1:
                    begin
                        send_idle_pct  = 62;
                        recv_stall_pct = 0;
                    end
                    2:
                    begin
                        send_idle_pct  = 0;
                        recv_stall_pct = 62;
                    end
                    default:
                    begin
                        send_idle_pct  = 14;
                        recv_stall_pct = 14;
                    end
                endcase
            end
            compose_uri();
            for (i = 0; i < uri_text.size(); i++)
                send_char(uri_text[i], i == uri_text.size() - 1, 1'b0, NO_RESULT);
        end
        text_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
